// ===== rtl/ihdp_pkg.sv =====
// Package: phase codes, tags and constants for the image header density parser.
package ihdp_pkg;
    localparam int OFFSET_BITS = 32;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    typedef enum logic [4:0] {
        PH_SIG_START = 5'd0,
        PH_SIG_PNG   = 5'd1,
        PH_SIG_JPG   = 5'd2,
        PH_SIG_BMP   = 5'd3,
        PH_PNG_LEN   = 5'd4,
        PH_PNG_TYPE  = 5'd5,
        PH_PNG_DATA  = 5'd6,
        PH_PNG_CRC   = 5'd7,
        PH_JPG_FF    = 5'd8,
        PH_JPG_MARK  = 5'd9,
        PH_JPG_LEN   = 5'd10,
        PH_JPG_DATA  = 5'd11,
        PH_BMP_BODY  = 5'd12,
        PH_DONE      = 5'd13
    } t_phase;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PNG  = 2'd1;
    localparam logic [1:0] KIND_JPG  = 2'd2;
    localparam logic [1:0] KIND_BMP  = 2'd3;

    localparam logic [31:0] TAG_PHYS = 32'h7048_5973;
    localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
    localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

    localparam logic [7:0] MK_SOI  = 8'hD8;
    localparam logic [7:0] MK_SOS  = 8'hDA;
    localparam logic [7:0] MK_EOI  = 8'hD9;
    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_TEM  = 8'h01;
    localparam logic [7:0] MK_RST0 = 8'hD0;
    localparam logic [7:0] MK_RST7 = 8'hD7;

    localparam logic [7:0] UNIT_INCH = 8'd1;
    localparam logic [7:0] UNIT_CM   = 8'd2;

    function automatic logic [7:0] png_sig(input logic [2:0] i);
        case (i)
            3'd0: png_sig = 8'h89;
            3'd1: png_sig = 8'h50;
            3'd2: png_sig = 8'h4E;
            3'd3: png_sig = 8'h47;
            3'd4: png_sig = 8'h0D;
            3'd5: png_sig = 8'h0A;
            3'd6: png_sig = 8'h1A;
            default: png_sig = 8'h0A;
        endcase
    endfunction

    function automatic logic [7:0] jfif_id(input logic [2:0] i);
        case (i)
            3'd0: jfif_id = 8'h4A;
            3'd1: jfif_id = 8'h46;
            3'd2: jfif_id = 8'h49;
            3'd3: jfif_id = 8'h46;
            default: jfif_id = 8'h00;
        endcase
    endfunction
endpackage

// ===== rtl/ihdp_conv.sv =====
// Density conversion: JFIF inch/cm values to Q8 pixels per meter; products registered, divide combinational.
module ihdp_conv (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [7:0]  i_unit,
    input  logic [15:0] i_x,
    input  logic [15:0] i_y,
    output logic [39:0] o_x,
    output logic [39:0] o_y
);
    import ihdp_pkg::*;

    // floor(d*1280000/127) = d*10078 + floor(d*94/127)
    logic [36:0] r_px, r_py;
    logic [22:0] r_rx, r_ry;
    logic        r_inch;
    logic [36:0] n_px, n_py;
    logic [22:0] n_rx, n_ry;

    always_comb begin
        if (i_unit == UNIT_INCH) begin
            n_px = 37'(i_x) * 37'd10078;
            n_py = 37'(i_y) * 37'd10078;
        end else begin
            n_px = 37'(i_x) * 37'd25600;
            n_py = 37'(i_y) * 37'd25600;
        end
        n_rx = 23'(i_x) * 23'd94;
        n_ry = 23'(i_y) * 23'd94;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= n_px;
            r_py   <= n_py;
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_inch <= (i_unit == UNIT_INCH);
        end
    end

    // divide by 127: q = (x * m) >> 30 with m = ceil(2^30/127), exact for x < 2^23
    function automatic logic [15:0] div127(input logic [22:0] x);
        logic [47:0] t;
        t = 48'(x) * 48'd8454661;
        div127 = 16'(t >> 30);
    endfunction

    assign o_x = r_inch ? 40'(r_px) + 40'(div127(r_rx)) : 40'(r_px);
    assign o_y = r_inch ? 40'(r_py) + 40'(div127(r_ry)) : 40'(r_py);
endmodule

// ===== rtl/image_header_density_parser_unit.sv =====
// Top level of the image header density parser.
// Takes one byte per cycle (every cycle if desired) while o_stall is low and after the byte marked
// last gives one result: found flag, source kind (PNG pHYs, JPEG JFIF, BMP) and X/Y density in pixels
// per meter, unsigned Q32.8. The byte parser updates its state once per byte; the result passes
// through the s1 and s2 registers (the JFIF unit conversion runs alongside them) into an output
// register, where it is held until taken. Afterwards the parser is back in reset state.
module image_header_density_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_found,
    output logic [1:0]  o_source_kind,
    output logic [39:0] o_x_density_q8,
    output logic [39:0] o_y_density_q8
);
    import ihdp_pkg::*;

    t_phase                 r_phase, n_phase;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [31:0]            r_len, n_len, r_rem, n_rem, r_tag, n_tag, r_fa, n_fa, r_fb, n_fb;
    logic [7:0]             r_unit, n_unit;
    logic                   r_hv, n_hv;
    logic [1:0]             r_hk, n_hk;
    logic [39:0]            r_hx, n_hx, r_hy, n_hy;
    logic                   jdone_ok;

    // pipeline: s1 (byte stage done, conversion started), s2 (conversion done), out register
    logic        r_s1_v, r_s2_v, r_o_v;
    logic        r_s1_found, r_s2_found;
    logic [1:0]  r_s1_kind, r_s2_kind;
    logic        r_s1_conv, r_s2_conv;
    logic [39:0] r_s1_x, r_s1_y, r_s2_x, r_s2_y;
    logic        n_fin_v, n_fin_found;
    logic [1:0]  n_fin_kind;
    logic [7:0]  n_cunit;
    logic [15:0] n_cx, n_cy;
    logic [39:0] cv_x, cv_y;
    logic        adv;
    logic        acc;
    logic [31:0] k;
    logic [7:0]  b;

    // pipeline moves whenever output register is free or being taken
    assign adv     = !r_o_v || !i_stall;
    assign o_stall = !adv;
    assign acc     = i_valid && adv;
    assign b       = i_data_byte;

    always_comb begin
        n_phase = r_phase; n_len = r_len; n_rem = r_rem; n_tag = r_tag;
        n_fa = r_fa; n_fb = r_fb; n_unit = r_unit;
        n_hv = r_hv; n_hk = r_hk; n_hx = r_hx; n_hy = r_hy;
        n_cunit = r_unit; n_cx = r_fa[15:0]; n_cy = r_fb[15:0];
        n_off = (r_off < OFF_MAX) ? r_off + 1'b1 : r_off;
        k = 32'd0;
        jdone_ok = 1'b0;
        case (r_phase)
            PH_SIG_START: begin
                if (b == 8'h89) n_phase = PH_SIG_PNG;
                else if (b == 8'hFF) n_phase = PH_SIG_JPG;
                else if (b == 8'h42) n_phase = PH_SIG_BMP;
                else n_phase = PH_DONE;
            end
            PH_SIG_PNG: begin
                if (r_off > 7 || b != png_sig(r_off[2:0])) n_phase = PH_DONE;
                else if (r_off == 7) begin
                    n_phase = PH_PNG_LEN; n_rem = 32'd4; n_len = 32'd0;
                end
            end
            PH_SIG_JPG: n_phase = (b == MK_SOI) ? PH_JPG_FF : PH_DONE;
            PH_SIG_BMP: begin
                if (b == 8'h4D) begin
                    n_phase = PH_BMP_BODY; n_len = 32'd0;
                end else n_phase = PH_DONE;
            end
            PH_PNG_LEN: begin
                n_len = {r_len[23:0], b};
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    n_phase = PH_PNG_TYPE; n_rem = 32'd4; n_tag = 32'd0;
                end
            end
            PH_PNG_TYPE: begin
                n_tag = {r_tag[23:0], b};
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    n_fa = 32'd0; n_fb = 32'd0; n_unit = 8'd0;
                    if (r_len == 0) begin
                        n_phase = PH_PNG_CRC; n_rem = 32'd4;
                    end else begin
                        n_phase = PH_PNG_DATA; n_rem = r_len;
                    end
                end
            end
            PH_PNG_DATA: begin
                k = r_len - r_rem;
                if (k < 4) n_fa = {r_fa[23:0], b};
                else if (k < 8) n_fb = {r_fb[23:0], b};
                else if (k == 8) n_unit = b;
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    n_phase = PH_PNG_CRC; n_rem = 32'd4;
                end
            end
            PH_PNG_CRC: begin
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    if (r_tag == TAG_PHYS && r_len >= 9 && r_unit == 8'd1) begin
                        n_hv = 1'b1; n_hk = KIND_PNG;
                        n_hx = {r_fa, 8'd0}; n_hy = {r_fb, 8'd0};
                        n_phase = PH_DONE;
                    end else if (r_tag == TAG_IDAT || r_tag == TAG_IEND) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = PH_PNG_LEN; n_rem = 32'd4; n_len = 32'd0;
                    end
                end
            end
            PH_JPG_FF: n_phase = (b == 8'hFF) ? PH_JPG_MARK : PH_DONE;
            PH_JPG_MARK: begin
                if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7))
                    n_phase = PH_JPG_FF;
                else if (b == MK_SOS || b == MK_EOI) n_phase = PH_DONE;
                else begin
                    n_tag = {24'd0, b}; n_len = 32'd0; n_rem = 32'd2; n_phase = PH_JPG_LEN;
                end
            end
            PH_JPG_LEN: begin
                n_len = {r_len[23:0], b};
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    if (n_len < 2) n_phase = PH_DONE;
                    else begin
                        n_fa = 32'd0; n_fb = 32'd0; n_unit = 8'd0;
                        n_rem = n_len - 32'd2;
                        // empty segment: fields are zero, never a valid JFIF
                        n_phase = (n_rem == 0) ? PH_JPG_FF : PH_JPG_DATA;
                    end
                end
            end
            PH_JPG_DATA: begin
                k = (r_len - 32'd2) - r_rem;
                if (k < 5) begin
                    if (b != jfif_id(k[2:0])) n_tag = r_tag | 32'h100;
                end else if (k == 7) n_unit = b;
                else if (k == 8 || k == 9) n_fa = {16'd0, r_fa[7:0], b};
                else if (k == 10 || k == 11) n_fb = {16'd0, r_fb[7:0], b};
                n_rem = r_rem - 1'b1;
                if (n_rem == 0) begin
                    n_phase = PH_JPG_FF;
                    jdone_ok = (n_tag[7:0] == MK_APP0) && !n_tag[8] && r_len >= 14
                               && (n_unit == UNIT_INCH || n_unit == UNIT_CM);
                    if (jdone_ok) begin
                        // value computed in the conversion unit; held slot marks it
                        n_hv = 1'b1; n_hk = KIND_JPG;
                        n_cunit = n_unit; n_cx = n_fa[15:0]; n_cy = n_fb[15:0];
                    end
                end
            end
            PH_BMP_BODY: begin
                if (r_off >= 14 && r_off <= 17)
                    n_len = r_len | (32'(b) << {r_off[1:0] - 2'd2, 3'd0});
                else if (r_off >= 38 && r_off <= 41)
                    n_fa = r_fa | (32'(b) << {r_off[1:0] - 2'd2, 3'd0});
                else if (r_off >= 42 && r_off <= 45)
                    n_fb = r_fb | (32'(b) << {r_off[1:0] - 2'd2, 3'd0});
                if (r_off == 45) begin
                    if (r_len >= 40 && n_fa != 0 && !n_fa[31] && n_fb != 0 && !n_fb[31]) begin
                        n_hv = 1'b1; n_hk = KIND_BMP;
                        n_hx = {n_fa, 8'd0}; n_hy = {n_fb, 8'd0};
                    end
                    n_phase = PH_DONE;
                end
            end
            default: n_phase = PH_DONE;
        endcase
        n_fin_v     = i_last_byte;
        n_fin_found = n_hv;
        n_fin_kind  = n_hv ? n_hk : KIND_NONE;
    end

    // latest JFIF inputs kept for conversion at end of file
    logic [7:0]  r_cunit;
    logic [15:0] r_cx, r_cy;
    logic [7:0]  sel_unit;
    logic [15:0] sel_x, sel_y;
    assign sel_unit = (acc && jdone_ok) ? n_cunit : r_cunit;
    assign sel_x    = (acc && jdone_ok) ? n_cx : r_cx;
    assign sel_y    = (acc && jdone_ok) ? n_cy : r_cy;

    ihdp_conv u_conv (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_unit (sel_unit),
        .i_x    (sel_x),
        .i_y    (sel_y),
        .o_x    (cv_x),
        .o_y    (cv_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SIG_START; r_off <= '0; r_len <= '0; r_rem <= '0; r_tag <= '0;
            r_fa <= '0; r_fb <= '0; r_unit <= '0; r_hv <= 1'b0; r_hk <= KIND_NONE;
            r_hx <= '0; r_hy <= '0; r_cunit <= '0; r_cx <= '0; r_cy <= '0;
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_o_v <= 1'b0;
        end else begin
            if (acc) begin
                if (i_last_byte) begin
                    r_phase <= PH_SIG_START; r_off <= '0; r_len <= '0; r_rem <= '0;
                    r_tag <= '0; r_fa <= '0; r_fb <= '0; r_unit <= '0; r_hv <= 1'b0;
                    r_hk <= KIND_NONE; r_hx <= '0; r_hy <= '0;
                end else begin
                    r_phase <= n_phase; r_off <= n_off; r_len <= n_len; r_rem <= n_rem;
                    r_tag <= n_tag; r_fa <= n_fa; r_fb <= n_fb; r_unit <= n_unit;
                    r_hv <= n_hv; r_hk <= n_hk; r_hx <= n_hx; r_hy <= n_hy;
                end
                if (jdone_ok) begin
                    r_cunit <= n_cunit; r_cx <= n_cx; r_cy <= n_cy;
                end
            end
            if (adv) begin
                r_s1_v <= acc && n_fin_v;
                r_s2_v <= r_s1_v;
                r_o_v  <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_found <= n_fin_found;
            r_s1_kind  <= n_fin_kind;
            r_s1_conv  <= n_fin_found && n_hk == KIND_JPG;
            r_s1_x     <= n_hv ? n_hx : 40'd0;
            r_s1_y     <= n_hv ? n_hy : 40'd0;
            r_s2_found <= r_s1_found;
            r_s2_kind  <= r_s1_kind;
            r_s2_conv  <= r_s1_conv;
            r_s2_x     <= r_s1_x;
            r_s2_y     <= r_s1_y;
            o_found        <= r_s2_found;
            o_source_kind  <= r_s2_kind;
            o_x_density_q8 <= r_s2_conv ? cv_x : r_s2_x;
            o_y_density_q8 <= r_s2_conv ? cv_y : r_s2_y;
        end
    end

    assign o_valid = r_o_v;
endmodule

// ===== rtl/ihdp_checker.sv =====
// Port-level checker for the image header density parser, bound to the top level.
module ihdp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_found,
    input logic [1:0]  o_source_kind,
    input logic [39:0] o_x_density_q8,
    input logic [39:0] o_y_density_q8
);
    import ihdp_pkg::*;

    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_source_kind == KIND_NONE && o_x_density_q8 == 40'd0
        && o_y_density_q8 == 40'd0) else $error("not-found result not zero");
    a_found_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> o_source_kind != KIND_NONE) else $error("found without kind");
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("stall without blocked output");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_density_q8) && $stable(o_found))
        else $error("stalled result changed");
endmodule

bind image_header_density_parser_unit ihdp_checker u_ihdp_checker (.*);

// ===== sim/density_checker.sv =====
// Checker for the image header density parser: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module density_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic        i_found,
    input  logic [1:0]  i_source_kind,
    input  logic [39:0] i_x_density_q8,
    input  logic [39:0] i_y_density_q8,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    import ihdp_pkg::*;

    typedef struct packed {
        logic        found;
        logic [1:0]  kind;
        logic [39:0] x;
        logic [39:0] y;
    } t_density;

    localparam logic [31:0] JPG_BAD_ID = 32'h100;

    t_density density_q[$];

    t_phase      phase;
    logic [31:0] offset;
    logic [31:0] seg_len;
    logic [31:0] seg_left;
    logic [31:0] seg_tag;
    logic [31:0] field_a;
    logic [31:0] field_b;
    logic [7:0]  unit_byte;
    logic        held_ok;
    logic [1:0]  held_kind;
    logic [39:0] held_x;
    logic [39:0] held_y;

    logic [7:0] sig_bytes [8] = '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A};
    logic [7:0] jfif_bytes [5] = '{8'h4A, 8'h46, 8'h49, 8'h46, 8'h00};

    task automatic clear_parser();
        phase = PH_SIG_START;
        offset = '0;
        seg_len = '0;
        seg_left = '0;
        seg_tag = '0;
        field_a = '0;
        field_b = '0;
        unit_byte = '0;
        held_ok = 1'b0;
        held_kind = KIND_NONE;
        held_x = '0;
        held_y = '0;
    endtask

    task automatic hold_density(input logic [1:0] kind, input logic [63:0] x,
                                input logic [63:0] y);
        held_ok = 1'b1;
        held_kind = kind;
        held_x = x[39:0];
        held_y = y[39:0];
    endtask

    task automatic png_chunk_end();
        if (seg_tag == TAG_PHYS && seg_len >= 9 && unit_byte == 8'd1) begin
            hold_density(KIND_PNG, {32'd0, field_a} << 8, {32'd0, field_b} << 8);
            phase = PH_DONE;
        end else if (seg_tag == TAG_IDAT || seg_tag == TAG_IEND) begin
            phase = PH_DONE;
        end else begin
            phase = PH_PNG_LEN;
            seg_left = 4;
            seg_len = 0;
        end
    endtask

    task automatic jpg_segment_end();
        logic [63:0] x;
        logic [63:0] y;
        x = {32'd0, field_a};
        y = {32'd0, field_b};
        if (seg_tag[7:0] == MK_APP0 && (seg_tag & JPG_BAD_ID) == 0 && seg_len >= 14) begin
            if (unit_byte == UNIT_INCH)
                hold_density(KIND_JPG, x * 64'd1280000 / 64'd127, y * 64'd1280000 / 64'd127);
            else if (unit_byte == UNIT_CM)
                hold_density(KIND_JPG, x * 64'd25600, y * 64'd25600);
        end
        phase = PH_JPG_FF;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic [31:0] k;
        case (phase)
            PH_SIG_START: begin
                if (b == 8'h89) phase = PH_SIG_PNG;
                else if (b == 8'hFF) phase = PH_SIG_JPG;
                else if (b == 8'h42) phase = PH_SIG_BMP;
                else phase = PH_DONE;
            end
            PH_SIG_PNG: begin
                if (offset > 7 || b != sig_bytes[offset[2:0]]) phase = PH_DONE;
                else if (offset == 7) begin
                    phase = PH_PNG_LEN;
                    seg_left = 4;
                    seg_len = 0;
                end
            end
            PH_SIG_JPG: phase = (b == MK_SOI) ? PH_JPG_FF : PH_DONE;
            PH_SIG_BMP: begin
                if (b == 8'h4D) begin
                    phase = PH_BMP_BODY;
                    seg_len = 0;
                end else phase = PH_DONE;
            end
            PH_PNG_LEN: begin
                seg_len = (seg_len << 8) | b;
                seg_left = seg_left - 1;
                if (seg_left == 0) begin
                    phase = PH_PNG_TYPE;
                    seg_left = 4;
                    seg_tag = 0;
                end
            end
            PH_PNG_TYPE: begin
                seg_tag = (seg_tag << 8) | b;
                seg_left = seg_left - 1;
                if (seg_left == 0) begin
                    field_a = 0;
                    field_b = 0;
                    unit_byte = 0;
                    seg_left = seg_len;
                    if (seg_len == 0) begin
                        phase = PH_PNG_CRC;
                        seg_left = 4;
                    end else phase = PH_PNG_DATA;
                end
            end
            PH_PNG_DATA: begin
                k = seg_len - seg_left;
                if (k < 4) field_a = (field_a << 8) | b;
                else if (k < 8) field_b = (field_b << 8) | b;
                else if (k == 8) unit_byte = b;
                seg_left = seg_left - 1;
                if (seg_left == 0) begin
                    phase = PH_PNG_CRC;
                    seg_left = 4;
                end
            end
            PH_PNG_CRC: begin
                seg_left = seg_left - 1;
                if (seg_left == 0) png_chunk_end();
            end
            PH_JPG_FF: phase = (b == 8'hFF) ? PH_JPG_MARK : PH_DONE;
            PH_JPG_MARK: begin
                if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7))
                    phase = PH_JPG_FF;
                else if (b == MK_SOS || b == MK_EOI) phase = PH_DONE;
                else begin
                    seg_tag = {24'd0, b};
                    seg_len = 0;
                    seg_left = 2;
                    phase = PH_JPG_LEN;
                end
            end
            PH_JPG_LEN: begin
                seg_len = (seg_len << 8) | b;
                seg_left = seg_left - 1;
                if (seg_left == 0) begin
                    if (seg_len < 2) phase = PH_DONE;
                    else begin
                        field_a = 0;
                        field_b = 0;
                        unit_byte = 0;
                        seg_left = seg_len - 2;
                        if (seg_left == 0) jpg_segment_end();
                        else phase = PH_JPG_DATA;
                    end
                end
            end
            PH_JPG_DATA: begin
                k = (seg_len - 2) - seg_left;
                if (k < 5) begin
                    if (b != jfif_bytes[k]) seg_tag = seg_tag | JPG_BAD_ID;
                end else if (k == 7) unit_byte = b;
                else if (k == 8 || k == 9) field_a = ((field_a << 8) | b) & 32'hFFFF;
                else if (k == 10 || k == 11) field_b = ((field_b << 8) | b) & 32'hFFFF;
                seg_left = seg_left - 1;
                if (seg_left == 0) jpg_segment_end();
            end
            PH_BMP_BODY: begin
                if (offset >= 14 && offset <= 17)
                    seg_len = seg_len | ({24'd0, b} << (8 * (offset - 14)));
                else if (offset >= 38 && offset <= 41)
                    field_a = field_a | ({24'd0, b} << (8 * (offset - 38)));
                else if (offset >= 42 && offset <= 45)
                    field_b = field_b | ({24'd0, b} << (8 * (offset - 42)));
                if (offset == 45) begin
                    if (seg_len >= 40 && field_a != 0 && !field_a[31] &&
                        field_b != 0 && !field_b[31])
                        hold_density(KIND_BMP, {32'd0, field_a} << 8, {32'd0, field_b} << 8);
                    phase = PH_DONE;
                end
            end
            default: phase = PH_DONE;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_density want;
        if (!i_rst_n) begin
            clear_parser();
            density_q.delete();
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count++;
                if (density_q.size() == 0) begin
                    report_mismatch("unexpected result", {38'd0, i_source_kind}, 40'd0);
                end else begin
                    want = density_q.pop_front();
                    if (i_found !== want.found)
                        report_mismatch("found", 40'(i_found), 40'(want.found));
                    if (i_source_kind !== want.kind)
                        report_mismatch("source_kind", 40'(i_source_kind), 40'(want.kind));
                    if (i_x_density_q8 !== want.x)
                        report_mismatch("x_density_q8", i_x_density_q8, want.x);
                    if (i_y_density_q8 !== want.y)
                        report_mismatch("y_density_q8", i_y_density_q8, want.y);
                end
            end
            if (i_valid && !i_stall_in) begin
                parse_byte(i_data_byte);
                if (offset != OFF_MAX) offset = offset + 1;
                if (i_last_byte) begin
                    want.found = held_ok;
                    want.kind = held_ok ? held_kind : KIND_NONE;
                    want.x = held_ok ? held_x : 40'd0;
                    want.y = held_ok ? held_y : 40'd0;
                    density_q.push_back(want);
                    clear_parser();
                end
            end
        end
        o_pending = density_q.size();
    end
endmodule

// ===== sim/image_header_density_parser_unit_tb.sv =====
// Testbench top: image file stimulus, idling and verdict for the density parser.
`timescale 1ns / 100ps
module image_header_density_parser_unit_tb;
    import ihdp_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_found;
    logic [1:0]  o_source_kind;
    logic [39:0] o_x_density_q8;
    logic [39:0] o_y_density_q8;

    int fail_count;
    int pending;
    int result_count;
    int bytes_sent;
    int files_sent;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    logic rx_hold;
    logic [7:0] file_q[$];

    image_header_density_parser_unit uut (.*);

    density_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_stall_in(o_stall), .i_data_byte, .i_last_byte,
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_found(o_found),
        .i_source_kind(o_source_kind), .i_x_density_q8(o_x_density_q8),
        .i_y_density_q8(o_y_density_q8), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > 400000) begin
                $display("timeout after %0d cycles", cycles);
                $display("FAIL image_header_density_parser_unit");
                $finish;
            end
        end
    end

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= rx_hold || ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic push_be32(input logic [31:0] v);
        file_q.push_back(v[31:24]);
        file_q.push_back(v[23:16]);
        file_q.push_back(v[15:8]);
        file_q.push_back(v[7:0]);
    endtask

    function automatic logic [31:0] pick32();
        case ($urandom_range(5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            4: return $urandom_range(20000);
            default: return $urandom;
        endcase
    endfunction

    task automatic make_png();
        int n;
        int len;
        logic [31:0] tag;
        for (int i = 0; i < 8; i++) file_q.push_back(i == 0 ? 8'h89 :
            (i == 1 ? 8'h50 : (i == 2 ? 8'h4E : (i == 3 ? 8'h47 :
            (i == 4 ? 8'h0D : (i == 6 ? 8'h1A : 8'h0A))))));
        if ($urandom_range(19) == 0) file_q[$urandom_range(7)] = 8'($urandom);
        n = $urandom_range(1, 3);
        for (int c = 0; c < n; c++) begin
            case ($urandom_range(9))
                0, 1: tag = 32'h4948_4452;
                2: tag = TAG_IDAT;
                3: tag = TAG_IEND;
                4: tag = $urandom;
                default: tag = TAG_PHYS;
            endcase
            len = (tag == TAG_PHYS && $urandom_range(3) != 0) ? 9 : $urandom_range(12);
            push_be32(32'(len));
            push_be32(tag);
            push_be32(pick32());
            push_be32(pick32());
            repeat (8) void'(file_q.pop_back());
            for (int k = 0; k < len; k++) begin
                if (k < 4 || k >= 9) file_q.push_back(8'($urandom));
                else if (k < 8) file_q.push_back(8'($urandom));
                else file_q.push_back(8'($urandom_range(3) == 0 ? $urandom_range(2) : 1));
            end
            push_be32($urandom);
        end
    endtask

    task automatic make_jpeg();
        int n;
        int len;
        file_q.push_back(8'hFF);
        file_q.push_back(MK_SOI);
        n = $urandom_range(1, 3);
        for (int s = 0; s < n; s++) begin
            case ($urandom_range(7))
                0: begin
                    file_q.push_back(8'hFF);
                    case ($urandom_range(2))
                        0: file_q.push_back(8'(MK_RST0 + $urandom_range(7)));
                        1: file_q.push_back(MK_TEM);
                        default: file_q.push_back(MK_SOI);
                    endcase
                end
                1: begin
                    len = $urandom_range(2, 6);
                    file_q.push_back(8'hFF);
                    file_q.push_back(8'($urandom_range(8'hE1, 8'hFE)));
                    file_q.push_back(8'h00);
                    file_q.push_back(8'(len));
                    repeat (len - 2) file_q.push_back(8'($urandom));
                end
                default: begin
                    len = ($urandom_range(4) == 0) ? $urandom_range(2, 18) : 16;
                    file_q.push_back(8'hFF);
                    file_q.push_back(MK_APP0);
                    file_q.push_back(8'h00);
                    file_q.push_back(8'(len));
                    for (int k = 0; k < len - 2; k++) begin
                        case (k)
                            0: file_q.push_back(8'h4A);
                            1: file_q.push_back(8'h46);
                            2: file_q.push_back(8'h49);
                            3: file_q.push_back(8'h46);
                            4: file_q.push_back(8'h00);
                            7: file_q.push_back(8'($urandom_range(3)));
                            8, 10: file_q.push_back(8'($urandom_range(1) ? 32'hFF : $urandom));
                            default: file_q.push_back(8'($urandom));
                        endcase
                    end
                    if (len >= 7 && $urandom_range(9) == 0) file_q[file_q.size() - len + 2 +
                        $urandom_range(4)] = 8'($urandom);
                end
            endcase
        end
        case ($urandom_range(5))
            0: begin file_q.push_back(8'hFF); file_q.push_back(MK_EOI); end
            1: begin file_q.push_back(8'hFF); file_q.push_back(MK_SOS); end
            2: file_q.push_back(8'($urandom_range(8'hFE)));
            3: begin
                file_q.push_back(8'hFF);
                file_q.push_back(8'hE2);
                file_q.push_back(8'h00);
                file_q.push_back(8'($urandom_range(1)));
            end
            default: ;
        endcase
    endtask

    task automatic make_bmp();
        logic [31:0] hsize;
        logic [31:0] xd;
        logic [31:0] yd;
        hsize = $urandom_range(2) ? 32'd40 : ($urandom_range(1) ? 32'd124 : pick32());
        xd = pick32();
        yd = pick32();
        file_q.push_back(8'h42);
        file_q.push_back(8'h4D);
        for (int off = 2; off < 46; off++) begin
            if (off >= 14 && off <= 17) file_q.push_back(8'(hsize >> (8 * (off - 14))));
            else if (off >= 38 && off <= 41) file_q.push_back(8'(xd >> (8 * (off - 38))));
            else if (off >= 42 && off <= 45) file_q.push_back(8'(yd >> (8 * (off - 42))));
            else file_q.push_back(8'($urandom));
        end
        repeat ($urandom_range(3)) file_q.push_back(8'($urandom));
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) begin
            @(negedge i_clk);
            while ($urandom_range(99) < tx_idle_pct) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_valid <= 1'b1;
            i_data_byte <= file_q[i];
            i_last_byte <= (i == file_q.size() - 1);
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            bytes_sent++;
        end
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_last_byte <= 1'b0;
        files_sent++;
        file_q.delete();
    endtask

    task automatic send_bytes(input logic [7:0] a, input logic [7:0] b, input int n);
        file_q.push_back(a);
        if (n > 1) file_q.push_back(b);
        send_file();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = 8'd0;
        i_last_byte = 1'b0;
        rx_hold = 1'b0;
        bytes_sent = 0;
        files_sent = 0;
        tx_idle_pct = 9;
        rx_idle_pct = 71;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // one- and two-byte files, minimal JPEG streams and a BMP file
        send_bytes(8'h00, 8'h00, 1);
        send_bytes(8'hFF, 8'h00, 1);
        send_bytes(8'h89, 8'h00, 1);
        send_bytes(8'h42, 8'h00, 2);
        send_bytes(8'h52, 8'h49, 2);
        file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hD9};
        send_file();
        file_q = '{8'hFF, 8'hD8, 8'hFF, 8'hE0, 8'h00, 8'h01};
        send_file();
        make_bmp();
        send_file();

        while (bytes_sent < 1050) begin
            if (bytes_sent > 700 && tx_idle_pct != 0) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                fork
                    begin
                        rx_hold = 1'b1;
                        repeat (300) @(negedge i_clk);
                        rx_hold = 1'b0;
                    end
                join_none
            end else if (bytes_sent > 350 && bytes_sent <= 700) begin
                tx_idle_pct = 71;
                rx_idle_pct = 9;
            end
            case ($urandom_range(9))
                0, 1, 2: make_png();
                3, 4, 5: make_jpeg();
                6, 7: make_bmp();
                default: repeat ($urandom_range(1, 6)) file_q.push_back(8'($urandom));
            endcase
            if ($urandom_range(9) == 0)
                while (file_q.size() > 1 && $urandom_range(3) != 0) void'(file_q.pop_back());
            send_file();
        end

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d files (%0d bytes) of PNG, JPEG, BMP and noise", files_sent,
                 bytes_sent);
        $display("checked %0d results under sender and receiver idling", result_count);
        if (fail_count == 0) begin
            $display("PASS image_header_density_parser_unit");
        end else begin
            $display("FAIL image_header_density_parser_unit");
        end
        $finish;
    end
endmodule
